// ===== src/cmtf_pkg.sv =====
package cmtf_pkg;

   localparam int PIX_W   = 8;
   localparam int NUM_CH  = 3;
   localparam int NUM_MAT = 2;
   localparam int PIX_MAX = 255;

   localparam logic TONE_SEPIA  = 1'b0;
   localparam logic TONE_MATRIX = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;

   // coefficients x 10000: [mode][out B,G,R][in R,G,B]
   localparam int COEF_E4 [NUM_MAT][NUM_CH][NUM_CH] = '{
      '{ '{  2720,  5340,   1310 }, '{ 3490,  6860, 1680 }, '{ 3930,  7690,   1890 } },
      '{ '{ -9689, 22415,  -6775 }, '{ 5782, -6287, 9845 }, '{ 2494, 22957, -13445 } }
   };

   // nearest multiple of 2^-frac, ties away from zero
   function automatic int to_fixed(input int k, input int frac);
      longint mag;
      longint q;
      mag = (k < 0) ? -longint'(k) : longint'(k);
      q   = (mag * (longint'(1) << frac) + 64'sd5000) / 64'sd10000;
      return (k < 0) ? -int'(q) : int'(q);
   endfunction

endpackage

// ===== src/color_matrix_tone_filter.sv =====
// Channel | Ports                               | Payload
// req     | req_tvalid req_tready req_tdata/last| blue_in, green_in, red_in; pixel_last
// rsp     | rsp_tvalid rsp_tready rsp_tdata/last| blue_out, green_out, red_out; out_last
// csr     | csr_valid csr_ready csr_data        | tone_mode
//
// Four register stages: input, products, sums, floor/clamp. One pixel per clock while
// the output is not stalled; rsp_tvalid rises when a req beat reaches the
// floor/clamp stage.
// The whole pipe advances together; it halts only while the output stage holds
// an untaken beat, and req_tready is low only then, so nothing is lost or repeated.
// Synchronous reset clears valid bits and tone_mode (sepia). csr_ready is always high.
module color_matrix_tone_filter #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] blue_in, [15:8] green_in, [23:16] red_in
   input  logic        req_tlast,   // pixel_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] blue_out, [15:8] green_out, [23:16] red_out
   output logic        rsp_tlast,   // out_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // tone_mode
);

   localparam int CW     = COEF_FRAC_BITS + 3;
   localparam int PW     = CW + cmtf_pkg::PIX_W + 1;
   localparam int SW     = PW + 2;
   localparam int STAGES = 4;

   logic                      advance;
   logic [STAGES-1:0]         vld_ff, vld_in;
   logic                      mode_ff, mode_in;
   logic                      s1_mode_ff;
   cmtf_pkg::pix_type         s1_pix_ff [cmtf_pkg::NUM_CH];   // R, G, B
   logic [STAGES-2:0]         last_ff;
   logic signed [CW-1:0]      coef [cmtf_pkg::NUM_CH][cmtf_pkg::NUM_CH];
   logic signed [PW-1:0]      s2_prod_ff [cmtf_pkg::NUM_CH][cmtf_pkg::NUM_CH];
   logic signed [SW-1:0]      s3_sum_ff [cmtf_pkg::NUM_CH];
   logic signed [SW-1:0]      s3_flr [cmtf_pkg::NUM_CH];
   cmtf_pkg::pix_type         s4_out_ff [cmtf_pkg::NUM_CH];   // B, G, R
   logic                      s4_last_ff;

   assign advance    = !vld_ff[STAGES-1] || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign vld_in     = {vld_ff[STAGES-2:0], req_tvalid};
   assign mode_in    = (csr_valid) ? csr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         mode_ff <= cmtf_pkg::TONE_SEPIA;
      end else begin
         mode_ff <= mode_in;
         if (advance) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_comb begin
      for (int c = 0; c < cmtf_pkg::NUM_CH; c++) begin
         for (int k = 0; k < cmtf_pkg::NUM_CH; k++) begin
            coef[c][k] = (s1_mode_ff == cmtf_pkg::TONE_MATRIX)
               ? CW'(cmtf_pkg::to_fixed(cmtf_pkg::COEF_E4[1][c][k], COEF_FRAC_BITS))
               : CW'(cmtf_pkg::to_fixed(cmtf_pkg::COEF_E4[0][c][k], COEF_FRAC_BITS));
         end
      end
   end

   always_comb begin
      for (int c = 0; c < cmtf_pkg::NUM_CH; c++) begin
         s3_flr[c] = s3_sum_ff[c] >>> COEF_FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff   <= mode_ff;
         s1_pix_ff[0] <= req_tdata[23:16];
         s1_pix_ff[1] <= req_tdata[15:8];
         s1_pix_ff[2] <= req_tdata[7:0];
         last_ff      <= {last_ff[STAGES-3:0], req_tlast};
         for (int c = 0; c < cmtf_pkg::NUM_CH; c++) begin
            for (int k = 0; k < cmtf_pkg::NUM_CH; k++) begin
               s2_prod_ff[c][k] <= PW'(coef[c][k] * $signed({1'b0, s1_pix_ff[k]}));
            end
            s3_sum_ff[c] <= SW'(s2_prod_ff[c][0]) + SW'(s2_prod_ff[c][1])
                          + SW'(s2_prod_ff[c][2]);
            priority if (s3_flr[c] < 0) begin
               s4_out_ff[c] <= '0;
            end else if (s3_flr[c] > SW'(cmtf_pkg::PIX_MAX)) begin
               s4_out_ff[c] <= cmtf_pkg::pix_type'(cmtf_pkg::PIX_MAX);
            end else begin
               s4_out_ff[c] <= s3_flr[c][cmtf_pkg::PIX_W-1:0];
            end
         end
         s4_last_ff <= last_ff[STAGES-2];
      end
   end

   assign rsp_tvalid = vld_ff[STAGES-1];
   assign rsp_tdata  = {s4_out_ff[2], s4_out_ff[1], s4_out_ff[0]};
   assign rsp_tlast  = s4_last_ff;

endmodule

// ===== src/cmtf_checker.sv =====
module cmtf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow output stage");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && csr_ready)
      else $error("pipe not empty after reset");

endmodule

bind color_matrix_tone_filter cmtf_checker u_cmtf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);
